[src/pes_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the particle Euler integrator.
// Command/status structs between controller and datapath, action and register codes.
package pes_pkg;

  // Command codes carried by the action field
  localparam logic [3:0] ACT_RESET   = 4'd0;
  localparam logic [3:0] ACT_CLEAR   = 4'd1;
  localparam logic [3:0] ACT_GRAVITY = 4'd2;
  localparam logic [3:0] ACT_HEAD    = 4'd3;
  localparam logic [3:0] ACT_SELF    = 4'd4;
  localparam logic [3:0] ACT_EULER   = 4'd5;
  localparam logic [3:0] ACT_GOAL    = 4'd6;
  localparam logic [3:0] ACT_PLACE   = 4'd7;
  localparam logic [3:0] ACT_SETVEL  = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_MASS      = 3'd1;
  localparam logic [2:0] CFG_GRAV_X    = 3'd2;
  localparam logic [2:0] CFG_GRAV_Y    = 3'd3;
  localparam logic [2:0] CFG_GRAV_Z    = 3'd4;
  localparam logic [2:0] CFG_RADIUS    = 3'd5;
  localparam logic [2:0] CFG_IS_ROOT   = 3'd6;

  // Datapath write-back operations
  typedef enum logic [3:0] {
    WB_NONE, WB_SIMPLE, WB_DIFF, WB_ACC, WB_T_DIV, WB_T_MULQ, WB_FORCE_ADD, WB_SELF,
    WB_VEL, WB_POS, WB_PROJ, WB_STILL, WB_TV, WB_GOALPOS, WB_PIN, WB_CONTACT
  } wb_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {M_DD, M_RT, M_DT_T, M_DT_VEL, M_REACH_D} mul_t;

  // Divider operand pairs
  typedef enum logic [1:0] {D_HEAD, D_ACC, D_PROJ, D_GOAL} dsel_t;

  typedef struct packed {
    logic       load_in;
    logic       load_out;
    wb_t        wb;
    mul_t       mul;
    dsel_t      dsel;
    logic       div_start;
    logic       sqrt_start;
    logic [1:0] k;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic len_zero;
    logic still;
    logic div_done;
    logic sqrt_done;
  } sts_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sh7FFF_FFFF;
    lo = -72'sh8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

[src/particle_euler_step_with_sphere.sv]
`timescale 1ns / 1ps
// Top level of the single-particle explicit Euler integrator with a sphere obstacle.
// Depends on pes_pkg, pes_ctrl and pes_dp (which holds pes_div and pes_sqrt).
//
// One particle lives in this block; every item on the input channel is one command
// (reset, clear force, add gravity, sphere force, self collision, Euler step, goal step,
// place, set velocity) and yields exactly one result item with the position, velocity
// and contact flag after the command. All values are signed fixed point with FRAC_BITS
// fraction bits and saturate to 32 bits. One item is worked at a time. A distance test
// squares the components and takes a 1-bit-per-cycle square root; each divide runs on a
// shared 2-bit-per-cycle divider, with three per sphere force, goal step that is not
// still or Euler acceleration, and three more when the Euler step projects out of the
// sphere. The latency is set by that shared divider and the square-root unit. The
// result sits in an output register, so a new item is taken as soon as the previous
// result has been loaded there. Write configuration only while idle; an index of 7 is
// ignored.
module particle_euler_step_with_sphere #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         action,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic               contact
);
  import pes_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per micro step, component index walks x, y, z
  pes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // particle state, arithmetic units and the result register
  pes_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .cmd       (cmd),
    .sts       (sts),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .contact   (contact)
  );

endmodule

[src/pes_div.sv]
`timescale 1ns / 1ps
// Sequential signed-by-unsigned divider, two quotient bits per cycle.
// Standalone; truncates toward zero and saturates the quotient to 34 bits.
module pes_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [64:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [33:0] quo
);

  logic [32:0] rem;
  logic [32:0] rem_n;
  logic [63:0] q;
  logic [63:0] q_n;
  logic [31:0] dreg;
  logic        neg;
  logic        busy;
  logic [4:0]  cnt;
  logic [64:0] mag;

  assign mag = num[64] ? (65'd0 - num) : num;

  always_comb begin
    rem_n = rem;
    q_n   = q;
    for (int i = 0; i < 2; i++) begin
      rem_n = {rem_n[31:0], q_n[63]};
      q_n   = {q_n[62:0], 1'b0};
      if (rem_n >= {1'b0, dreg}) begin
        rem_n = rem_n - {1'b0, dreg};
        q_n[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= mag[63:0];
      dreg <= den;
      neg  <= num[64];
    end else if (busy) begin
      rem <= rem_n;
      q   <= q_n;
    end
  end

  always_comb begin
    if (!neg) begin
      quo = (|q[63:33]) ? {1'b0, {33{1'b1}}} : {1'b0, q[32:0]};
    end else if ((|q[63:34]) || (q[33] && (|q[32:0]))) begin
      quo = {1'b1, 33'd0};
    end else begin
      quo = 34'd0 - q[33:0];
    end
  end

endmodule

[src/pes_sqrt.sv]
`timescale 1ns / 1ps
// Sequential integer square root of a 64-bit value, one result bit per cycle.
// Standalone; the root is floor(sqrt(radicand)).
module pes_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] b;
  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] trial;

  assign trial = r + b;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= radicand;
      r <= '0;
      b <= 64'd1 << 62;
    end else if (busy) begin
      if (v >= trial) begin
        v <= v - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end

endmodule

[src/pes_dp.sv]
`timescale 1ns / 1ps
// Datapath: particle state, configuration registers, multiplier, divider and square root.
// Depends on pes_pkg, pes_div and pes_sqrt; driven by pes_ctrl commands.
module pes_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [3:0]          action,
  input  logic signed [31:0]  vec_x,
  input  logic signed [31:0]  vec_y,
  input  logic signed [31:0]  vec_z,
  input  pes_pkg::cmd_t       cmd,
  output pes_pkg::sts_t       sts,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic signed [31:0]  vel_x,
  output logic signed [31:0]  vel_y,
  output logic signed [31:0]  vel_z,
  output logic                contact
);
  import pes_pkg::*;

  localparam logic [32:0]        NEAR = 33'(((2 ** FRAC_BITS) + 50) / 100);
  localparam logic signed [32:0] TINY = 33'(((2 ** FRAC_BITS) + 50000) / 100000);

  logic [30:0]        time_step;
  logic [30:0]        particle_mass;
  logic [30:0]        head_radius;
  logic               is_root;
  logic signed [31:0] grav [3];

  logic signed [31:0] pos  [3];
  logic signed [31:0] vel  [3];
  logic signed [31:0] pp   [3];
  logic signed [31:0] pv   [3];
  logic signed [31:0] frc  [3];
  logic signed [31:0] home [3];
  logic               contact_flag;

  logic [3:0]         act;
  logic signed [31:0] vin [3];
  logic signed [31:0] d   [3];
  logic [63:0]        acc;
  logic signed [31:0] t;
  logic signed [67:0] prod;

  logic [1:0]         kk;
  logic signed [31:0] dk;
  logic signed [31:0] qm;
  logic [32:0]        reach;
  logic [31:0]        len;
  logic signed [32:0] g [3];
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [64:0] div_num;
  logic [31:0]        div_den;
  logic signed [33:0] quo;
  logic [30:0]        m_eff;
  logic [30:0]        dt_eff;

  assign kk     = cmd.k;
  assign dk     = d[kk];
  assign qm     = sat32(72'(prod >>> FRAC_BITS));
  assign reach  = {2'b00, head_radius} + NEAR;
  assign m_eff  = (particle_mass == '0) ? 31'd1 : particle_mass;
  assign dt_eff = (time_step == '0) ? 31'd1 : time_step;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g[i] = 33'(vin[i]) - 33'(pp[i]);
    end
  end

  assign sts.still    = (g[0] < TINY) && (g[1] < TINY) && (g[2] < TINY);
  assign sts.len_zero = (len == '0);
  assign sts.hit      = (act == ACT_SELF) ? ({1'b0, len} < NEAR) : ({1'b0, len} < reach);

  // Multiplier operand selection
  always_comb begin
    unique case (cmd.mul)
      M_DD: begin
        mul_a = 34'(dk);
        mul_b = 34'(dk);
      end
      M_RT: begin
        mul_a = $signed({3'b000, head_radius});
        mul_b = 34'(t);
      end
      M_DT_T: begin
        mul_a = $signed({3'b000, time_step});
        mul_b = 34'(t);
      end
      M_DT_VEL: begin
        mul_a = $signed({3'b000, time_step});
        mul_b = 34'(vel[kk]);
      end
      M_REACH_D: begin
        mul_a = $signed({1'b0, reach});
        mul_b = 34'(dk);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider operand selection
  always_comb begin
    unique case (cmd.dsel)
      D_HEAD: begin
        div_num = 65'(dk) <<< FRAC_BITS;
        div_den = len;
      end
      D_ACC: begin
        div_num = 65'(frc[kk]) <<< FRAC_BITS;
        div_den = {1'b0, m_eff};
      end
      D_PROJ: begin
        div_num = $signed(prod[64:0]);
        div_den = len;
      end
      D_GOAL: begin
        div_num = 65'(g[kk]) <<< FRAC_BITS;
        div_den = {1'b0, dt_eff};
      end
      default: begin
        div_num = '0;
        div_den = 32'd1;
      end
    endcase
  end

  pes_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (sts.div_done),
    .quo   (quo)
  );

  pes_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (acc),
    .done     (sts.sqrt_done),
    .root     (len)
  );

  // Configuration and particle state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step     <= 31'd655;
      particle_mass <= 31'd65536;
      head_radius   <= 31'd65536;
      is_root       <= 1'b0;
      contact_flag  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        grav[i] <= '0;
        pos[i]  <= '0;
        vel[i]  <= '0;
        pp[i]   <= '0;
        pv[i]   <= '0;
        frc[i]  <= '0;
        home[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TIME_STEP: time_step     <= cfg_data[30:0];
          CFG_MASS:      particle_mass <= cfg_data[30:0];
          CFG_GRAV_X:    grav[0]       <= cfg_data;
          CFG_GRAV_Y:    grav[1]       <= cfg_data;
          CFG_GRAV_Z:    grav[2]       <= cfg_data;
          CFG_RADIUS:    head_radius   <= cfg_data[30:0];
          CFG_IS_ROOT:   is_root       <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load_in) contact_flag <= 1'b0;
      unique case (cmd.wb)
        WB_SIMPLE: begin
          case (act)
            ACT_RESET: begin
              for (int i = 0; i < 3; i++) begin
                pos[i] <= home[i];
                vel[i] <= '0;
                pp[i]  <= '0;
                pv[i]  <= '0;
                frc[i] <= '0;
              end
            end
            ACT_CLEAR: begin
              for (int i = 0; i < 3; i++) frc[i] <= '0;
            end
            ACT_GRAVITY: begin
              for (int i = 0; i < 3; i++) frc[i] <= sat32(72'(frc[i]) + 72'(grav[i]));
            end
            ACT_PLACE: begin
              for (int i = 0; i < 3; i++) begin
                pos[i]  <= vin[i];
                home[i] <= vin[i];
                pp[i]   <= vin[i];
              end
            end
            ACT_SETVEL: begin
              for (int i = 0; i < 3; i++) vel[i] <= vin[i];
            end
            default: ;
          endcase
        end
        WB_SELF: begin
          contact_flag <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            frc[i] <= sat32(72'(frc[i]) + 72'(d[i]) + 72'(d[i]));
          end
        end
        WB_CONTACT:   contact_flag <= 1'b1;
        WB_FORCE_ADD: frc[kk] <= sat32(72'(frc[kk]) + 72'(qm));
        WB_VEL: begin
          pv[kk]  <= vel[kk];
          vel[kk] <= sat32(72'(vel[kk]) + 72'(qm));
        end
        WB_POS: begin
          pp[kk]  <= pos[kk];
          pos[kk] <= sat32(72'(pos[kk]) + 72'(qm));
        end
        WB_PROJ:    pos[kk] <= sat32(72'(vin[kk]) + 72'(quo));
        WB_GOALPOS: pos[kk] <= sat32(72'(pp[kk]) + 72'(qm));
        WB_STILL: begin
          for (int i = 0; i < 3; i++) vel[i] <= '0;
        end
        WB_PIN: begin
          if (is_root) begin
            for (int i = 0; i < 3; i++) begin
              pos[i] <= home[i];
              vel[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Operand and scratch registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_in) begin
      act    <= action;
      vin[0] <= vec_x;
      vin[1] <= vec_y;
      vin[2] <= vec_z;
    end
    unique case (cmd.wb)
      WB_DIFF: begin
        for (int i = 0; i < 3; i++) d[i] <= sat32(72'(pos[i]) - 72'(vin[i]));
        acc <= '0;
      end
      WB_ACC:    acc <= acc + prod[63:0];
      WB_T_DIV:  t <= sat32(72'(quo));
      WB_T_MULQ: t <= qm;
      WB_TV:     t <= sat32(72'(pv[kk]) + 72'(sat32(72'(quo))));
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_x   <= pos[0];
      pos_y   <= pos[1];
      pos_z   <= pos[2];
      vel_x   <= vel[0];
      vel_y   <= vel[1];
      vel_z   <= vel[2];
      contact <= contact_flag;
    end
  end

endmodule

[src/pes_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences each command through the datapath one component at a time.
// Depends on pes_pkg; drives pes_dp through cmd_t and reads sts_t.
module pes_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    action,
  output logic          out_valid,
  input  logic          out_ready,
  input  pes_pkg::sts_t sts,
  output pes_pkg::cmd_t cmd
);
  import pes_pkg::*;

  typedef enum logic [29:0] {
    ST_IDLE      = 30'd1 << 0,
    ST_SIMPLE    = 30'd1 << 1,
    ST_DIFF      = 30'd1 << 2,
    ST_SQ_MUL    = 30'd1 << 3,
    ST_SQ_ACC    = 30'd1 << 4,
    ST_SQRT_GO   = 30'd1 << 5,
    ST_SQRT_WAIT = 30'd1 << 6,
    ST_CHECK     = 30'd1 << 7,
    ST_HD_DIV    = 30'd1 << 8,
    ST_HD_WAIT   = 30'd1 << 9,
    ST_HD_MUL1   = 30'd1 << 10,
    ST_HD_T      = 30'd1 << 11,
    ST_HD_MUL2   = 30'd1 << 12,
    ST_HD_ADD    = 30'd1 << 13,
    ST_EU_DIV    = 30'd1 << 14,
    ST_EU_WAIT   = 30'd1 << 15,
    ST_EU_MUL    = 30'd1 << 16,
    ST_EU_VEL    = 30'd1 << 17,
    ST_EU_PMUL   = 30'd1 << 18,
    ST_EU_POS    = 30'd1 << 19,
    ST_PJ_MUL    = 30'd1 << 20,
    ST_PJ_DIV    = 30'd1 << 21,
    ST_PJ_WAIT   = 30'd1 << 22,
    ST_GO_CHECK  = 30'd1 << 23,
    ST_GO_DIV    = 30'd1 << 24,
    ST_GO_WAIT   = 30'd1 << 25,
    ST_GO_MUL    = 30'd1 << 26,
    ST_GO_POS    = 30'd1 << 27,
    ST_PIN       = 30'd1 << 28,
    ST_OUT       = 30'd1 << 29
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] k;
  logic [1:0] k_next;
  logic [3:0] act;
  logic [3:0] act_next;
  logic       last;

  assign last = (k == 2'd2);

  always_comb begin
    state_next = state;
    k_next     = k;
    act_next   = act;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.wb     = WB_NONE;
    cmd.mul    = M_DD;
    cmd.dsel   = D_HEAD;
    cmd.k      = k;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          act_next    = action;
          k_next      = '0;
          case (action)
            ACT_HEAD, ACT_SELF: state_next = ST_DIFF;
            ACT_EULER:          state_next = ST_EU_DIV;
            ACT_GOAL:           state_next = ST_GO_CHECK;
            default:            state_next = ST_SIMPLE;
          endcase
        end
      end
      ST_SIMPLE: begin
        cmd.wb     = WB_SIMPLE;
        state_next = ST_OUT;
      end
      ST_DIFF: begin
        cmd.wb     = WB_DIFF;
        k_next     = '0;
        state_next = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        cmd.mul    = M_DD;
        state_next = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        cmd.wb = WB_ACC;
        if (last) begin
          k_next     = '0;
          state_next = ST_SQRT_GO;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sts.sqrt_done) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        k_next = '0;
        if (act == ACT_SELF) begin
          if (sts.hit) cmd.wb = WB_SELF;
          state_next = ST_OUT;
        end else if (act == ACT_HEAD) begin
          if (sts.hit) cmd.wb = WB_CONTACT;
          state_next = (sts.hit && !sts.len_zero) ? ST_HD_DIV : ST_OUT;
        end else begin
          if (sts.hit) cmd.wb = WB_CONTACT;
          state_next = (sts.hit && !sts.len_zero) ? ST_PJ_MUL : ST_PIN;
        end
      end
      ST_HD_DIV: begin
        cmd.dsel      = D_HEAD;
        cmd.div_start = 1'b1;
        state_next    = ST_HD_WAIT;
      end
      ST_HD_WAIT: begin
        if (sts.div_done) begin
          cmd.wb     = WB_T_DIV;
          state_next = ST_HD_MUL1;
        end
      end
      ST_HD_MUL1: begin
        cmd.mul    = M_RT;
        state_next = ST_HD_T;
      end
      ST_HD_T: begin
        cmd.wb     = WB_T_MULQ;
        state_next = ST_HD_MUL2;
      end
      ST_HD_MUL2: begin
        cmd.mul    = M_RT;
        state_next = ST_HD_ADD;
      end
      ST_HD_ADD: begin
        cmd.wb = WB_FORCE_ADD;
        if (last) begin
          state_next = ST_OUT;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_HD_DIV;
        end
      end
      ST_EU_DIV: begin
        cmd.dsel      = D_ACC;
        cmd.div_start = 1'b1;
        state_next    = ST_EU_WAIT;
      end
      ST_EU_WAIT: begin
        if (sts.div_done) begin
          cmd.wb     = WB_T_DIV;
          state_next = ST_EU_MUL;
        end
      end
      ST_EU_MUL: begin
        cmd.mul    = M_DT_T;
        state_next = ST_EU_VEL;
      end
      ST_EU_VEL: begin
        cmd.wb = WB_VEL;
        if (last) begin
          k_next     = '0;
          state_next = ST_EU_PMUL;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_EU_DIV;
        end
      end
      ST_EU_PMUL: begin
        cmd.mul    = M_DT_VEL;
        state_next = ST_EU_POS;
      end
      ST_EU_POS: begin
        cmd.wb = WB_POS;
        if (last) begin
          k_next     = '0;
          state_next = ST_DIFF;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_EU_PMUL;
        end
      end
      ST_PJ_MUL: begin
        cmd.mul    = M_REACH_D;
        state_next = ST_PJ_DIV;
      end
      ST_PJ_DIV: begin
        cmd.dsel      = D_PROJ;
        cmd.div_start = 1'b1;
        state_next    = ST_PJ_WAIT;
      end
      ST_PJ_WAIT: begin
        if (sts.div_done) begin
          cmd.wb = WB_PROJ;
          if (last) begin
            state_next = ST_PIN;
          end else begin
            k_next     = k + 2'd1;
            state_next = ST_PJ_MUL;
          end
        end
      end
      ST_GO_CHECK: begin
        k_next = '0;
        if (sts.still) begin
          cmd.wb     = WB_STILL;
          state_next = ST_PIN;
        end else begin
          state_next = ST_GO_DIV;
        end
      end
      ST_GO_DIV: begin
        cmd.dsel      = D_GOAL;
        cmd.div_start = 1'b1;
        state_next    = ST_GO_WAIT;
      end
      ST_GO_WAIT: begin
        if (sts.div_done) begin
          cmd.wb     = WB_TV;
          state_next = ST_GO_MUL;
        end
      end
      ST_GO_MUL: begin
        cmd.mul    = M_DT_T;
        state_next = ST_GO_POS;
      end
      ST_GO_POS: begin
        cmd.wb = WB_GOALPOS;
        if (last) begin
          state_next = ST_PIN;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_GO_DIV;
        end
      end
      ST_PIN: begin
        cmd.wb     = WB_PIN;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold the finished item until the result register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      act       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      act       <= act_next;
      out_valid <= cmd.load_out | (out_valid & ~out_ready);
    end
  end

endmodule

[tb/particle_euler_step_with_sphere_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for particle_euler_step_with_sphere.
// Depends on pes_pkg for the action and register codes; needs only the RTL.
//
// A bit-exact predictor of the particle is kept beside the block and fed each
// accepted command. A directed table runs first, then randomized phases under
// several register settings and idling patterns. Each result item is compared
// field by field against the oldest expected state.
module particle_euler_step_with_sphere_test;
  import pes_pkg::*;

  localparam logic [3:0] ACT_UNUSED = 4'd15;  // outside the command set
  localparam logic [2:0] CFG_UNUSED = 3'd7;   // register index the block ignores
  localparam longint ONE_Q  = 64'sd65536;
  localparam longint NEAR_Q = 64'sd655;
  localparam longint TINY_Q = 64'sd1;
  localparam int INT_MAX = 32'sh7FFF_FFFF;
  localparam int INT_MIN = 32'sh8000_0000;
  localparam int RAND_PER_PHASE = 115;

  typedef struct {
    int p[3];
    int v[3];
    bit c;
  } particle_state_t;

  typedef struct {
    logic [3:0] act;
    int         x, y, z;
    bit         typed;      // expectation given in the row itself
    particle_state_t st;
  } cmd_row_t;

  logic clk, rst;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [3:0] action;
  logic signed [31:0] vec_x, vec_y, vec_z;
  logic out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
  logic contact;

  particle_euler_step_with_sphere dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- predictor
  // Register copies and particle state, updated in acceptance order.
  int unsigned dt_q, mass_q, radius_q;
  bit          pinned;
  int          grav[3];
  int          p_now[3], v_now[3], p_old[3], v_old[3], f_sum[3], p_home[3];

  particle_state_t expected_states[$];
  int mismatches;
  int results_seen;
  int contacts_seen;
  int items_sent;

  function automatic int clip(longint v);
    if (v > longint'(INT_MAX)) return INT_MAX;
    if (v < longint'(INT_MIN)) return INT_MIN;
    return int'(v);
  endfunction

  // Fixed-point product, rounded toward minus infinity.
  function automatic int fx_mul(longint a, longint b);
    return clip((a * b) >>> 16);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Saturated difference position - vec and its length.
  function automatic longint unsigned gap_len(int a[3], longint b[3], output int d[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = clip(longint'(a[i]) - b[i]);
      s += longint'(d[i]) * longint'(d[i]);
    end
    return int_root(s);
  endfunction

  task automatic pin_to_home();
    if (pinned) begin
      for (int i = 0; i < 3; i++) begin
        p_now[i] = p_home[i];
        v_now[i] = 0;
      end
    end
  endtask

  task automatic apply_config(logic [2:0] idx, logic [31:0] val);
    case (idx)
      CFG_TIME_STEP: dt_q = val & 32'h7FFF_FFFF;
      CFG_MASS:      mass_q = val & 32'h7FFF_FFFF;
      CFG_GRAV_X:    grav[0] = int'(val);
      CFG_GRAV_Y:    grav[1] = int'(val);
      CFG_GRAV_Z:    grav[2] = int'(val);
      CFG_RADIUS:    radius_q = val & 32'h7FFF_FFFF;
      CFG_IS_ROOT:   pinned = val[0];
      default: ;
    endcase
  endtask

  // Advance the particle by one command and return the state it reports.
  task automatic advance_particle(logic [3:0] act, int x, int y, int z,
                                  output particle_state_t st);
    longint vv[3], g[3];
    int d[3];
    longint unsigned len;
    longint r, dt, m, reach, u, dv;
    int t, a, q, tv;
    bit hit, still;
    vv[0] = x;
    vv[1] = y;
    vv[2] = z;
    r = radius_q;
    dt = dt_q;
    hit = 1'b0;
    case (act)
      ACT_RESET: begin
        for (int i = 0; i < 3; i++) begin
          p_now[i] = p_home[i];
          v_now[i] = 0;
          p_old[i] = 0;
          v_old[i] = 0;
          f_sum[i] = 0;
        end
      end
      ACT_CLEAR: for (int i = 0; i < 3; i++) f_sum[i] = 0;
      ACT_GRAVITY:
        for (int i = 0; i < 3; i++) f_sum[i] = clip(longint'(f_sum[i]) + grav[i]);
      ACT_HEAD: begin
        len = gap_len(p_now, vv, d);
        if (len < longint'(NEAR_Q + r)) begin
          hit = 1'b1;
          if (len > 0) begin
            for (int i = 0; i < 3; i++) begin
              u = (longint'(d[i]) * ONE_Q) / longint'(len);
              t = fx_mul(r, u);
              f_sum[i] = clip(longint'(f_sum[i]) + fx_mul(t, r));
            end
          end
        end
      end
      ACT_SELF: begin
        len = gap_len(p_now, vv, d);
        if (len < NEAR_Q) begin
          hit = 1'b1;
          for (int i = 0; i < 3; i++)
            f_sum[i] = clip(longint'(f_sum[i]) + 2 * longint'(d[i]));
        end
      end
      ACT_EULER: begin
        m = (mass_q != 0) ? longint'(mass_q) : 1;
        reach = r + NEAR_Q;
        for (int i = 0; i < 3; i++) begin
          a = clip((longint'(f_sum[i]) * ONE_Q) / m);
          v_old[i] = v_now[i];
          v_now[i] = clip(longint'(v_now[i]) + fx_mul(dt, a));
        end
        for (int i = 0; i < 3; i++) begin
          p_old[i] = p_now[i];
          p_now[i] = clip(longint'(p_now[i]) + fx_mul(dt, v_now[i]));
        end
        len = gap_len(p_now, vv, d);
        if (len < reach) begin
          hit = 1'b1;
          if (len > 0)
            for (int i = 0; i < 3; i++)
              p_now[i] = clip(vv[i] + (reach * longint'(d[i])) / longint'(len));
        end
        pin_to_home();
      end
      ACT_GOAL: begin
        still = 1'b1;
        dv = (dt != 0) ? dt : 1;
        for (int i = 0; i < 3; i++) begin
          g[i] = vv[i] - longint'(p_old[i]);
          if (!(g[i] < TINY_Q)) still = 1'b0;
        end
        if (still) begin
          for (int i = 0; i < 3; i++) v_now[i] = 0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            q = clip((g[i] * ONE_Q) / dv);
            tv = clip(longint'(v_old[i]) + q);
            p_now[i] = clip(longint'(p_old[i]) + fx_mul(dt, tv));
          end
        end
        pin_to_home();
      end
      ACT_PLACE: begin
        for (int i = 0; i < 3; i++) begin
          p_now[i] = int'(vv[i]);
          p_home[i] = p_now[i];
          p_old[i] = p_now[i];
        end
      end
      ACT_SETVEL: for (int i = 0; i < 3; i++) v_now[i] = int'(vv[i]);
      default: ;
    endcase
    st.p = p_now;
    st.v = v_now;
    st.c = hit;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
  endtask

  always @(posedge clk) begin
    particle_state_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (contact) contacts_seen++;
      if (expected_states.size() == 0) begin
        mismatches++;
        $display("[%0t] result item with nothing expected", $realtime);
      end else begin
        want = expected_states.pop_front();
        if (pos_x !== want.p[0]) report_mismatch("pos_x", pos_x, want.p[0]);
        if (pos_y !== want.p[1]) report_mismatch("pos_y", pos_y, want.p[1]);
        if (pos_z !== want.p[2]) report_mismatch("pos_z", pos_z, want.p[2]);
        if (vel_x !== want.v[0]) report_mismatch("vel_x", vel_x, want.v[0]);
        if (vel_y !== want.v[1]) report_mismatch("vel_y", vel_y, want.v[1]);
        if (vel_z !== want.v[2]) report_mismatch("vel_z", vel_z, want.v[2]);
        if (contact !== want.c) report_mismatch("contact", contact, want.c);
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  int  stall_pct;     // chance per cycle that the receiver stalls
  int  send_idle_pct; // chance per cycle that the sender idles
  bit  hold_request;
  int  hold_left;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- sender
  // Offer one command, hold it until taken, then predict its result.
  task automatic send_command(logic [3:0] act, int x, int y, int z,
                              bit typed = 1'b0, particle_state_t typed_st = '{default: 0});
    particle_state_t st;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    do @(posedge clk); while (!in_ready);
    advance_particle(act, x, y, z, st);
    expected_states.push_back(typed ? typed_st : st);
    items_sent++;
  endtask

  // Drop valid, let all results drain, then allow for a command still in flight.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_config(idx, val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] dt, logic [31:0] m, logic [31:0] gx,
                           logic [31:0] gy, logic [31:0] gz, logic [31:0] rad,
                           logic [31:0] root);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_MASS, m);
    write_reg(CFG_GRAV_X, gx);
    write_reg(CFG_GRAV_Y, gy);
    write_reg(CFG_GRAV_Z, gz);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_IS_ROOT, root);
  endtask

  // One operand component: near a base point, small, extreme or fully random.
  function automatic int pick_component(int base, int spread);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return clip(longint'(base) + $signed($urandom_range(2 * spread)) - spread);
    if (sel < 80) return $signed($urandom_range(8 << 16)) - (4 << 16);
    if (sel < 88) begin
      case ($urandom_range(4))
        0: return INT_MAX;
        1: return INT_MIN;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random();
    int sel, spread, base[3], x, y, z;
    logic [3:0] act;
    sel = $urandom_range(99);
    base = p_now;
    spread = 1 << 16;
    if (sel < 8) act = ACT_PLACE;
    else if (sel < 13) act = ACT_SETVEL;
    else if (sel < 18) act = ACT_RESET;
    else if (sel < 24) act = ACT_CLEAR;
    else if (sel < 34) act = ACT_GRAVITY;
    else if (sel < 48) act = ACT_HEAD;
    else if (sel < 58) act = ACT_SELF;
    else if (sel < 84) act = ACT_EULER;
    else if (sel < 95) act = ACT_GOAL;
    else act = 4'($urandom_range(15, 9));
    case (act)
      ACT_HEAD:  spread = (radius_q > 32'd1000) ? (radius_q > (8 << 16) ? (8 << 16) : radius_q)
                                                : 1000;
      ACT_SELF:  spread = 600;
      ACT_GOAL: begin
        base = p_old;
        spread = $urandom_range(1) ? 3 : (2 << 16);
      end
      ACT_PLACE: spread = 8 << 16;
      default: ;
    endcase
    x = pick_component(base[0], spread);
    y = pick_component(base[1], spread);
    z = pick_component(base[2], spread);
    send_command(act, x, y, z);
  endtask

  // ---------------------------------------------------------------- main flow
  cmd_row_t directed[$];

  function automatic particle_state_t st_of(int px, int py, int pz, int vx, int vy, int vz,
                                            bit c);
    particle_state_t s;
    s.p = '{px, py, pz};
    s.v = '{vx, vy, vz};
    s.c = c;
    return s;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_CLEAR;
    vec_x = 0;
    vec_y = 0;
    vec_z = 0;
    out_ready = 1'b0;
    stall_pct = 0;
    send_idle_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    mismatches = 0;
    results_seen = 0;
    contacts_seen = 0;
    items_sent = 0;
    dt_q = 655;
    mass_q = 65536;
    radius_q = 65536;
    pinned = 1'b0;
    for (int i = 0; i < 3; i++) begin
      grav[i] = 0;
      p_now[i] = 0;
      v_now[i] = 0;
      p_old[i] = 0;
      v_old[i] = 0;
      f_sum[i] = 0;
      p_home[i] = 0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed commands from the reset state, default registers.
    // Expectations are typed in where they follow directly from the command.
    directed.push_back('{ACT_CLEAR, 0, 0, 0, 1, st_of(0, 0, 0, 0, 0, 0, 0)});
    directed.push_back('{ACT_PLACE, INT_MAX, INT_MIN, 0, 1,
                         st_of(INT_MAX, INT_MIN, 0, 0, 0, 0, 0)});
    directed.push_back('{ACT_SETVEL, INT_MIN, INT_MAX, -1, 1,
                         st_of(INT_MAX, INT_MIN, 0, INT_MIN, INT_MAX, -1, 0)});
    // Unknown command leaves the state alone.
    directed.push_back('{ACT_UNUSED, 32'h5A5A_A5A5, -1, INT_MIN, 1,
                         st_of(INT_MAX, INT_MIN, 0, INT_MIN, INT_MAX, -1, 0)});
    directed.push_back('{ACT_RESET, 0, 0, 0, 1, st_of(INT_MAX, INT_MIN, 0, 0, 0, 0, 0)});
    // Zero-length distance: contact but no force.
    directed.push_back('{ACT_HEAD, INT_MAX, INT_MIN, 0, 1,
                         st_of(INT_MAX, INT_MIN, 0, 0, 0, 0, 1)});
    directed.push_back('{ACT_SELF, INT_MAX, INT_MIN, 0, 1,
                         st_of(INT_MAX, INT_MIN, 0, 0, 0, 0, 1)});
    directed.push_back('{ACT_EULER, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_PLACE, 0, 0, 0, 1, st_of(0, 0, 0, 0, 0, 0, 0)});
    directed.push_back('{ACT_HEAD, 1 << 15, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_GRAVITY, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_SELF, 100, -200, 50, 0, '{default: 0}});
    directed.push_back('{ACT_EULER, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_EULER, 100 << 16, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_GOAL, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_GOAL, 1 << 16, 2 << 16, -(1 << 16), 0, '{default: 0}});
    directed.push_back('{ACT_SETVEL, 1 << 16, 0, -(3 << 16), 0, '{default: 0}});
    directed.push_back('{ACT_EULER, INT_MAX, INT_MAX, INT_MAX, 0, '{default: 0}});
    directed.push_back('{ACT_HEAD, INT_MIN, INT_MIN, INT_MIN, 0, '{default: 0}});
    directed.push_back('{ACT_EULER, 1 << 14, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_CLEAR, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{ACT_RESET, 0, 0, 0, 0, '{default: 0}});
    foreach (directed[i])
      send_command(directed[i].act, directed[i].x, directed[i].y, directed[i].z,
                   directed[i].typed, directed[i].st);
    wait_idle();

    // Randomized phases, each under its own register setting and idling pattern.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_all(655, 65536, 0, 0, 0, 65536, 0);
          stall_pct = 0;
          send_idle_pct = 0;
        end
        1: begin
          write_all(6554, 32768, 1000, -642253, 20000, 131072, 0);
          stall_pct = 0;
          send_idle_pct = 70;
        end
        2: begin
          // Largest step, smallest mass, extreme gravity and radius.
          write_all(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h8000_0000, 12345,
                    32'h7FFF_FFFF, 0);
          stall_pct = 70;
          send_idle_pct = 0;
        end
        3: begin
          // Zero step and zero mass, point-sized sphere, pinned particle.
          write_all(0, 0, -5000, 7000, -1, 0, 1);
          stall_pct = 6;
          send_idle_pct = 6;
        end
        4: begin
          // Top data bits must be masked; the unused index must be ignored.
          write_all(32'hFFFF_FFFF, 32'h8001_0000, 32'hFFFF_0000, 0, 32'h0001_0000,
                    32'h8003_0000, 32'hFFFF_FFFE);
          write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
          write_reg(CFG_TIME_STEP, 1);
          stall_pct = 0;
          send_idle_pct = 0;
        end
        default: begin
          write_all(65536, 2147483647, 300000, -300000, 0, 3 << 16, 1);
          write_reg(CFG_IS_ROOT, 0);
          stall_pct = $urandom_range(50);
          send_idle_pct = $urandom_range(50);
        end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // Hold the receiver off for a long stretch while commands keep coming.
        if (ph == 4 && n == 10) hold_request = 1'b1;
        send_random();
      end
      wait_idle();
    end

    $display("Covered %0d commands over 6 register settings, %0d results, %0d with contact.",
             items_sent, results_seen, contacts_seen);
    $display("Idling: none, sender-heavy, receiver-heavy, light, and one long receiver hold.");
    if (mismatches == 0 && expected_states.size() == 0)
      $display("** particle_euler_step_with_sphere: PASSED **");
    else
      $display("** particle_euler_step_with_sphere: FAILED **");
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20ms;
    $display("Timeout with %0d results still expected.", expected_states.size());
    $display("** particle_euler_step_with_sphere: FAILED **");
    $finish;
  end

endmodule
